@@ rtl/core/mvpf_pkg.sv @@
// shared types, codes and helper functions for the memory view pixel fetcher
package mvpf_pkg;

   localparam logic [7:0] MAX_BYTES_WIDE = 8'd255;
   localparam logic [8:0] MAX_LINES      = 9'd511;

   localparam logic [4:0] SPR_LINES = 5'd21;
   localparam logic [1:0] SPR_BYTES = 2'd3;

   localparam logic [2:0] MODE_LINES   = 3'd0;
   localparam logic [2:0] MODE_COLUMNS = 3'd1;
   localparam logic [2:0] MODE_TILES   = 3'd2;
   localparam logic [2:0] MODE_SPRITES = 3'd3;
   localparam logic [2:0] MODE_TEXT    = 3'd4;

   localparam logic [2:0] REG_LAYOUT_MODE  = 3'd0;
   localparam logic [2:0] REG_DISPLAY_BASE = 3'd1;
   localparam logic [2:0] REG_FONT_BASE    = 3'd2;
   localparam logic [2:0] REG_BYTES_WIDE   = 3'd3;
   localparam logic [2:0] REG_LINES_HIGH   = 3'd4;

   localparam logic [2:0]  RESET_LAYOUT_MODE  = MODE_TEXT;
   localparam logic [15:0] RESET_DISPLAY_BASE = 16'd1024;
   localparam logic [15:0] RESET_FONT_BASE    = 16'd61440;
   localparam logic [7:0]  RESET_BYTES_WIDE   = 8'd40;
   localparam logic [8:0]  RESET_LINES_HIGH   = 9'd200;

   typedef struct packed {
      logic [2:0]  layout_mode;
      logic [15:0] display_base;
      logic [15:0] font_base;
      logic [7:0]  width;
      logic [8:0]  lines;
      logic [6:0]  sprite_cols;
      logic [4:0]  sprite_rows;
   } cfg_type;

   typedef struct packed {
      logic        frame_active;
      logic        char_phase;
      logic [15:0] fetch_pointer;
      logic [15:0] font_pointer;
      logic [8:0]  row_count;
      logic [7:0]  column_count;
      logic [4:0]  subline_count;
      logic [1:0]  slot_count;
      logic [6:0]  sprite_columns;
      logic [4:0]  sprite_rows;
   } state_type;

   typedef struct packed {
      logic        fetch_valid;
      logic [15:0] fetch_address;
      logic        pixel_valid;
      logic [8:0]  pixel_line;
      logic [7:0]  pixel_byte_column;
      logic [7:0]  pixel_pattern;
      logic        frame_done;
   } result_type;

   function automatic logic [7:0] clamp_width(input logic [7:0] w);
      return (w < MAX_BYTES_WIDE) ? w : MAX_BYTES_WIDE;
   endfunction

   function automatic logic [8:0] clamp_lines(input logic [8:0] h);
      return (h < MAX_LINES) ? h : MAX_LINES;
   endfunction

   // floor(w / 3) for any 8-bit w, by reciprocal multiply
   function automatic logic [6:0] div_by_3(input logic [7:0] w);
      logic [15:0] p;
      p = {8'd0, w} * 16'd171;
      return p[15:9];
   endfunction

   // floor(h / 21) for h below 512, by reciprocal multiply
   function automatic logic [4:0] div_by_21(input logic [8:0] h);
      logic [19:0] p;
      p = {11'd0, h} * 20'd1561;
      return p[19:15];
   endfunction

endpackage

@@ rtl/core/mvpf_csr.sv @@
// configuration registers with clamped limits and sprite grid counts
module mvpf_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [2:0]           csr_index,
   input  logic [15:0]          csr_data,
   output mvpf_pkg::cfg_type    cfg
);

   mvpf_pkg::cfg_type cfg_ff;
   mvpf_pkg::cfg_type cfg_in;
   logic [7:0]        new_width;
   logic [8:0]        new_lines;

   assign csr_ready = 1'b1;
   assign new_width = mvpf_pkg::clamp_width(csr_data[7:0]);
   assign new_lines = mvpf_pkg::clamp_lines(csr_data[8:0]);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            mvpf_pkg::REG_LAYOUT_MODE: begin
               cfg_in.layout_mode = csr_data[2:0];
            end
            mvpf_pkg::REG_DISPLAY_BASE: begin
               cfg_in.display_base = csr_data;
            end
            mvpf_pkg::REG_FONT_BASE: begin
               cfg_in.font_base = csr_data;
            end
            mvpf_pkg::REG_BYTES_WIDE: begin
               cfg_in.width       = new_width;
               cfg_in.sprite_cols = mvpf_pkg::div_by_3(new_width);
            end
            mvpf_pkg::REG_LINES_HIGH: begin
               cfg_in.lines       = new_lines;
               cfg_in.sprite_rows = mvpf_pkg::div_by_21(new_lines);
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.layout_mode  <= mvpf_pkg::RESET_LAYOUT_MODE;
         cfg_ff.display_base <= mvpf_pkg::RESET_DISPLAY_BASE;
         cfg_ff.font_base    <= mvpf_pkg::RESET_FONT_BASE;
         cfg_ff.width        <= mvpf_pkg::clamp_width(mvpf_pkg::RESET_BYTES_WIDE);
         cfg_ff.lines        <= mvpf_pkg::clamp_lines(mvpf_pkg::RESET_LINES_HIGH);
         cfg_ff.sprite_cols  <= mvpf_pkg::div_by_3(
                                   mvpf_pkg::clamp_width(mvpf_pkg::RESET_BYTES_WIDE));
         cfg_ff.sprite_rows  <= mvpf_pkg::div_by_21(
                                   mvpf_pkg::clamp_lines(mvpf_pkg::RESET_LINES_HIGH));
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ rtl/core/mvpf_walk.sv @@
// next walk state and result for one transfer, all layouts
module mvpf_walk (
   input  mvpf_pkg::cfg_type    cfg,
   input  mvpf_pkg::state_type  cur,
   input  logic                 start_req,
   input  logic [7:0]           read_data,
   output mvpf_pkg::state_type  nxt,
   output mvpf_pkg::result_type res
);

   logic [15:0] fp_inc;
   logic [7:0]  col_inc;
   logic [8:0]  row_inc;
   logic [4:0]  sub_inc;
   logic [5:0]  sub_wide;
   logic [1:0]  slot_inc;
   logic [6:0]  scol_inc;
   logic [4:0]  srow_inc;
   logic [8:0]  tile_line;
   logic [9:0]  spr_row_mul;
   logic [8:0]  spr_line;
   logic [7:0]  spr_col;
   logic [4:0]  t_sub;
   logic [7:0]  t_col;
   logic [8:0]  t_row;
   logic        t_end;
   logic        empty;
   logic        ended;

   assign fp_inc      = cur.fetch_pointer + 16'd1;
   assign col_inc     = cur.column_count + 8'd1;
   assign row_inc     = cur.row_count + 9'd1;
   assign sub_inc     = cur.subline_count + 5'd1;
   assign sub_wide    = {1'b0, cur.subline_count} + 6'd1;
   assign slot_inc    = cur.slot_count + 2'd1;
   assign scol_inc    = cur.sprite_columns + 7'd1;
   assign srow_inc    = cur.sprite_rows + 5'd1;
   assign tile_line   = {cur.row_count[5:0], 3'b000} + {4'd0, cur.subline_count};
   assign spr_row_mul = {5'd0, cur.sprite_rows} * {5'd0, mvpf_pkg::SPR_LINES};
   assign spr_line    = spr_row_mul[8:0] + {4'd0, cur.subline_count};
   assign spr_col     = ({1'b0, cur.sprite_columns} * {6'd0, mvpf_pkg::SPR_BYTES})
                        + {6'd0, cur.slot_count};

   // tile and text byte grid: eight sublines, then columns, then rows of eight lines
   always_comb begin
      t_sub = sub_inc;
      t_col = cur.column_count;
      t_row = cur.row_count;
      t_end = 1'b0;
      if (sub_inc >= 5'd8) begin
         t_sub = 5'd0;
         t_col = col_inc;
         if (col_inc >= cfg.width) begin
            t_col = 8'd0;
            t_row = row_inc;
            t_end = (row_inc >= {3'd0, cfg.lines[8:3]});
         end
      end
   end

   always_comb begin
      case (cfg.layout_mode)
         mvpf_pkg::MODE_LINES, mvpf_pkg::MODE_COLUMNS: begin
            empty = (cfg.width == 8'd0) || (cfg.lines == 9'd0);
         end
         mvpf_pkg::MODE_TILES, mvpf_pkg::MODE_TEXT: begin
            empty = (cfg.width == 8'd0) || (cfg.lines[8:3] == 6'd0);
         end
         mvpf_pkg::MODE_SPRITES: begin
            empty = (cfg.sprite_cols == 7'd0) || (cfg.sprite_rows == 5'd0);
         end
         default: begin
            empty = 1'b1;
         end
      endcase
   end

   always_comb begin
      nxt   = cur;
      res   = '0;
      ended = 1'b0;
      if (start_req) begin
         nxt                = '0;
         nxt.fetch_pointer  = cfg.display_base;
         if (empty) begin
            res.frame_done = 1'b1;
         end else begin
            nxt.frame_active  = 1'b1;
            res.fetch_valid   = 1'b1;
            res.fetch_address = cfg.display_base;
         end
      end else if (cur.frame_active) begin
         case (cfg.layout_mode)
            mvpf_pkg::MODE_LINES: begin
               res.pixel_valid       = 1'b1;
               res.pixel_line        = cur.row_count;
               res.pixel_byte_column = cur.column_count;
               res.pixel_pattern     = read_data;
               nxt.fetch_pointer     = fp_inc;
               nxt.column_count      = col_inc;
               if (col_inc >= cfg.width) begin
                  nxt.column_count = 8'd0;
                  nxt.row_count    = row_inc;
                  ended            = (row_inc >= cfg.lines);
               end
               res.fetch_address = fp_inc;
            end
            mvpf_pkg::MODE_COLUMNS: begin
               res.pixel_valid       = 1'b1;
               res.pixel_line        = cur.row_count;
               res.pixel_byte_column = cur.column_count;
               res.pixel_pattern     = read_data;
               nxt.fetch_pointer     = fp_inc;
               nxt.row_count         = row_inc;
               if (row_inc >= cfg.lines) begin
                  nxt.row_count    = 9'd0;
                  nxt.column_count = col_inc;
                  ended            = (col_inc >= cfg.width);
               end
               res.fetch_address = fp_inc;
            end
            mvpf_pkg::MODE_TILES: begin
               res.pixel_valid       = 1'b1;
               res.pixel_line        = tile_line;
               res.pixel_byte_column = cur.column_count;
               res.pixel_pattern     = read_data;
               nxt.fetch_pointer     = fp_inc;
               nxt.subline_count     = t_sub;
               nxt.column_count      = t_col;
               nxt.row_count         = t_row;
               ended                 = t_end;
               res.fetch_address     = fp_inc;
            end
            mvpf_pkg::MODE_SPRITES: begin
               res.pixel_valid       = 1'b1;
               res.pixel_line        = spr_line;
               res.pixel_byte_column = spr_col;
               res.pixel_pattern     = read_data;
               nxt.fetch_pointer     = fp_inc;
               nxt.slot_count        = slot_inc;
               if (slot_inc >= mvpf_pkg::SPR_BYTES) begin
                  nxt.slot_count    = 2'd0;
                  nxt.subline_count = sub_inc;
                  if (sub_inc >= mvpf_pkg::SPR_LINES) begin
                     // skip the pad byte at the end of each sprite
                     nxt.subline_count  = 5'd0;
                     nxt.fetch_pointer  = fp_inc + 16'd1;
                     nxt.sprite_columns = scol_inc;
                     if (scol_inc >= cfg.sprite_cols) begin
                        nxt.sprite_columns = 7'd0;
                        nxt.sprite_rows    = srow_inc;
                        ended              = (srow_inc >= cfg.sprite_rows);
                     end
                  end
               end
               res.fetch_address = nxt.fetch_pointer;
            end
            mvpf_pkg::MODE_TEXT: begin
               if (!cur.char_phase) begin
                  nxt.font_pointer  = cfg.font_base + {5'd0, read_data, 3'b000};
                  nxt.fetch_pointer = fp_inc;
                  nxt.char_phase    = 1'b1;
                  nxt.subline_count = 5'd0;
                  res.fetch_address = nxt.font_pointer;
               end else begin
                  res.pixel_valid       = 1'b1;
                  res.pixel_line        = tile_line;
                  res.pixel_byte_column = cur.column_count;
                  res.pixel_pattern     = read_data;
                  nxt.font_pointer      = cur.font_pointer + 16'd1;
                  nxt.char_phase        = (sub_wide < 6'd8);
                  nxt.subline_count     = t_sub;
                  nxt.column_count      = t_col;
                  nxt.row_count         = t_row;
                  ended                 = t_end;
                  res.fetch_address     = nxt.char_phase ? nxt.font_pointer
                                                         : cur.fetch_pointer;
               end
            end
            default: begin
               ended = 1'b1;
            end
         endcase
         if (ended) begin
            nxt.frame_active  = 1'b0;
            nxt.char_phase    = 1'b0;
            res.frame_done    = 1'b1;
            res.fetch_address = 16'd0;
         end else begin
            res.fetch_valid = 1'b1;
         end
      end
   end

endmodule

@@ rtl/core/memory_view_pixel_fetcher.sv @@
// memory view pixel fetcher top level: input register, walk logic, result register
// Takes one transfer per cycle unless rsp_tready holds the result register: a start
// transfer (req_tuser set) opens a frame and the result carries the first fetch
// address; every later transfer carries the byte read for the previous fetch and
// gets back the next fetch address plus, for pattern bytes, the destination line,
// byte column and eight pixels. Each transfer passes through the input register,
// the combinational walk logic and the result register. Configuration writes are
// taken at once and are meant for idle.
module memory_view_pixel_fetcher (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // read_data
   input  logic        req_tuser,   // start_req
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // fetch_address, pixel_line, pixel_byte_column,
                                    // pixel_pattern, zero pad
   output logic [1:0]  rsp_tuser,   // fetch_valid, pixel_valid
   output logic        rsp_tlast,   // frame_done
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   mvpf_pkg::cfg_type    cfg;
   mvpf_pkg::state_type  state_ff;
   mvpf_pkg::state_type  state_in;
   mvpf_pkg::result_type res_in;
   mvpf_pkg::result_type res_ff;

   logic       in_valid_ff;
   logic       in_start_ff;
   logic [7:0] in_data_ff;
   logic       out_valid_ff;
   logic       advance;

   mvpf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   mvpf_walk u_walk (
      .cfg       (cfg),
      .cur       (state_ff),
      .start_req (in_start_ff),
      .read_data (in_data_ff),
      .nxt       (state_in),
      .res       (res_in)
   );

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_start_ff <= req_tuser;
         in_data_ff  <= req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            state_ff     <= state_in;
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         res_ff <= res_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'd0, res_ff.pixel_pattern, res_ff.pixel_byte_column,
                        res_ff.pixel_line, res_ff.fetch_address};
   assign rsp_tuser  = {res_ff.pixel_valid, res_ff.fetch_valid};
   assign rsp_tlast  = res_ff.frame_done;

   // a frame end never asks for another fetch
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && res_ff.frame_done |-> !res_ff.fetch_valid)
      else $error("frame end result carries a fetch");

   // pixels are either followed by a fetch or close the frame
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && res_ff.pixel_valid |-> res_ff.fetch_valid || res_ff.frame_done)
      else $error("pixel result with no fetch and no frame end");

   // the frame closes once its last result is formed
   assert property (@(posedge clock) disable iff (reset)
      advance && res_in.frame_done |=> !state_ff.frame_active)
      else $error("frame still open after its end");

   // text phase is only held inside an open frame
   assert property (@(posedge clock) disable iff (reset)
      !state_ff.frame_active |-> !state_ff.char_phase)
      else $error("character phase set with no open frame");

endmodule

@@ verif/memory_view_pixel_fetcher_tb.sv @@
// self-checking testbench for the memory view pixel fetcher, checked against a predictor
module memory_view_pixel_fetcher_tb;

   localparam int CYCLE_LIMIT = 300000;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int FRAME_ITEMS_CAP = 300;
   localparam logic [2:0] MODE_UNDEF_LOW = 3'd5;
   localparam logic [2:0] MODE_UNDEF_HIGH = 3'd7;

   typedef struct packed {
      logic        start;
      logic [7:0]  data;
   } mem_reply_type;

   typedef struct {
      logic [2:0]  layout_mode;
      logic [15:0] display_base;
      logic [15:0] font_base;
      logic [7:0]  bytes_wide;
      logic [8:0]  lines_high;
   } view_regs_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;   // read_data
   logic        req_tuser = 1'b0; // start_req
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;        // fetch_address, pixel_line, pixel_byte_column,
                                  // pixel_pattern, zero pad
   logic [1:0]  rsp_tuser;        // fetch_valid, pixel_valid
   logic        rsp_tlast;        // frame_done
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_data = '0;

   view_regs_type         cfg;
   mvpf_pkg::state_type   walk;
   mem_reply_type         pending_replies[$];
   mvpf_pkg::result_type  predicted_results[$];
   mem_reply_type         next_reply;
   mvpf_pkg::result_type  want;

   int mismatches = 0;
   int results_seen = 0;
   int cycle_count = 0;
   int burst_left = 1;
   int gap_left = 0;
   int rx_style = 0;
   int long_hold_left = 0;
   logic long_hold_req = 1'b0;
   logic long_hold_done = 1'b0;

   memory_view_pixel_fetcher i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // tile and text grid: next subline, then column, then 8-line row
   function automatic logic tile_advance(input int w, input int h);
      walk.subline_count = walk.subline_count + 5'd1;
      if (walk.subline_count < 8) return 1'b0;
      walk.subline_count = '0;
      walk.column_count = walk.column_count + 8'd1;
      if (walk.column_count < w) return 1'b0;
      walk.column_count = '0;
      walk.row_count = walk.row_count + 9'd1;
      return walk.row_count >= h / 8;
   endfunction

   function automatic mvpf_pkg::result_type fetch_walk(input logic start,
                                                       input logic [7:0] d);
      mvpf_pkg::result_type r;
      int w, h, t;
      logic ended;
      r = '0;
      ended = 1'b0;
      w = int'(cfg.bytes_wide);
      h = int'(cfg.lines_high);
      if (start) begin
         walk = '0;
         walk.fetch_pointer = cfg.display_base;
         case (cfg.layout_mode)
            mvpf_pkg::MODE_LINES, mvpf_pkg::MODE_COLUMNS: ended = (w == 0 || h == 0);
            mvpf_pkg::MODE_TILES, mvpf_pkg::MODE_TEXT: ended = (w == 0 || h < 8);
            mvpf_pkg::MODE_SPRITES:
               ended = (w < mvpf_pkg::SPR_BYTES || h < mvpf_pkg::SPR_LINES);
            default: ended = 1'b1;
         endcase
         if (ended) begin
            r.frame_done = 1'b1;
         end else begin
            walk.frame_active = 1'b1;
            r.fetch_valid = 1'b1;
            r.fetch_address = walk.fetch_pointer;
         end
      end else if (walk.frame_active) begin
         if (cfg.layout_mode <= mvpf_pkg::MODE_SPRITES) begin
            r.pixel_valid = 1'b1;
            r.pixel_pattern = d;
            r.pixel_line = walk.row_count;
            r.pixel_byte_column = walk.column_count;
            walk.fetch_pointer = walk.fetch_pointer + 16'd1;
         end
         case (cfg.layout_mode)
            mvpf_pkg::MODE_LINES: begin
               walk.column_count = walk.column_count + 8'd1;
               if (walk.column_count >= w) begin
                  walk.column_count = '0;
                  walk.row_count = walk.row_count + 9'd1;
                  ended = (walk.row_count >= h);
               end
            end
            mvpf_pkg::MODE_COLUMNS: begin
               walk.row_count = walk.row_count + 9'd1;
               if (walk.row_count >= h) begin
                  walk.row_count = '0;
                  walk.column_count = walk.column_count + 8'd1;
                  ended = (walk.column_count >= w);
               end
            end
            mvpf_pkg::MODE_TILES: begin
               t = walk.row_count * 8 + walk.subline_count;
               r.pixel_line = t[8:0];
               ended = tile_advance(w, h);
            end
            mvpf_pkg::MODE_SPRITES: begin
               t = walk.sprite_rows * mvpf_pkg::SPR_LINES + walk.subline_count;
               r.pixel_line = t[8:0];
               t = walk.sprite_columns * mvpf_pkg::SPR_BYTES + walk.slot_count;
               r.pixel_byte_column = t[7:0];
               walk.slot_count = walk.slot_count + 2'd1;
               if (walk.slot_count >= mvpf_pkg::SPR_BYTES) begin
                  walk.slot_count = '0;
                  walk.subline_count = walk.subline_count + 5'd1;
                  if (walk.subline_count >= mvpf_pkg::SPR_LINES) begin
                     // pad byte at the end of each sprite is skipped
                     walk.subline_count = '0;
                     walk.fetch_pointer = walk.fetch_pointer + 16'd1;
                     walk.sprite_columns = walk.sprite_columns + 7'd1;
                     if (walk.sprite_columns >= w / mvpf_pkg::SPR_BYTES) begin
                        walk.sprite_columns = '0;
                        walk.sprite_rows = walk.sprite_rows + 5'd1;
                        ended = (walk.sprite_rows >= h / mvpf_pkg::SPR_LINES);
                     end
                  end
               end
            end
            mvpf_pkg::MODE_TEXT: begin
               if (!walk.char_phase) begin
                  t = cfg.font_base + 8 * d;
                  walk.font_pointer = t[15:0];
                  walk.fetch_pointer = walk.fetch_pointer + 16'd1;
                  walk.char_phase = 1'b1;
                  walk.subline_count = '0;
                  r.fetch_address = walk.font_pointer;
               end else begin
                  r.pixel_valid = 1'b1;
                  t = walk.row_count * 8 + walk.subline_count;
                  r.pixel_line = t[8:0];
                  r.pixel_byte_column = walk.column_count;
                  r.pixel_pattern = d;
                  walk.font_pointer = walk.font_pointer + 16'd1;
                  if (walk.subline_count >= 7) walk.char_phase = 1'b0;
                  ended = tile_advance(w, h);
                  r.fetch_address = walk.char_phase ? walk.font_pointer : walk.fetch_pointer;
               end
            end
            default: ended = 1'b1;
         endcase
         if (cfg.layout_mode != mvpf_pkg::MODE_TEXT) r.fetch_address = walk.fetch_pointer;
         if (ended) begin
            walk.frame_active = 1'b0;
            walk.char_phase = 1'b0;
            r.frame_done = 1'b1;
            r.fetch_address = '0;
         end else begin
            r.fetch_valid = 1'b1;
         end
      end
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 40) $display("mismatch at %0t: %s", $time, msg);
   endtask

   task automatic check_field(input string name, input logic [15:0] got,
                              input logic [15:0] exp_val);
      if (got !== exp_val)
         report_mismatch($sformatf("result %0d %s got 0x%0h expected 0x%0h",
                                   results_seen, name, got, exp_val));
   endtask

   task automatic queue_item(input logic start, input logic [7:0] data);
      mem_reply_type b;
      b.start = start;
      b.data = data;
      pending_replies.push_back(b);
   endtask

   // caller lowers csr_valid after the last write of a group
   task automatic write_reg(input logic [2:0] index, input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (index)
         mvpf_pkg::REG_LAYOUT_MODE: cfg.layout_mode = value[2:0];
         mvpf_pkg::REG_DISPLAY_BASE: cfg.display_base = value;
         mvpf_pkg::REG_FONT_BASE: cfg.font_base = value;
         mvpf_pkg::REG_BYTES_WIDE: cfg.bytes_wide = value[7:0];
         mvpf_pkg::REG_LINES_HIGH: cfg.lines_high = value[8:0];
         default: ;
      endcase
   endtask

   task automatic drain();
      while (pending_replies.size() != 0 || req_tvalid || predicted_results.size() != 0)
         @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // sender: bursts of transfers with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            predicted_results.push_back(fetch_walk(req_tuser, req_tdata));
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left = gap_left - 1;
               req_tvalid <= 1'b0;
            end else if (pending_replies.size() != 0) begin
               next_reply = pending_replies.pop_front();
               req_tvalid <= 1'b1;
               req_tuser <= next_reply.start;
               req_tdata <= next_reply.data;
               burst_left = burst_left - 1;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 24);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // one long receiver hold-off
   always @(posedge clock) begin
      if (reset) begin
         long_hold_left <= 0;
      end else if (long_hold_left != 0) begin
         long_hold_left <= long_hold_left - 1;
      end else if (long_hold_req && !long_hold_done) begin
         long_hold_left <= LONG_HOLD_CYCLES;
         long_hold_done <= 1'b1;
      end
   end

   // receiver: checks each result transfer, stalls on its own pattern
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (predicted_results.size() == 0) begin
               report_mismatch($sformatf("result %0d arrived with nothing expected",
                                         results_seen));
            end else begin
               want = predicted_results.pop_front();
               check_field("fetch_valid", 16'(rsp_tuser[0]), 16'(want.fetch_valid));
               check_field("fetch_address", rsp_tdata[15:0], want.fetch_address);
               check_field("pixel_valid", 16'(rsp_tuser[1]), 16'(want.pixel_valid));
               check_field("pixel_line", 16'(rsp_tdata[24:16]), 16'(want.pixel_line));
               check_field("pixel_byte_column", 16'(rsp_tdata[32:25]),
                           16'(want.pixel_byte_column));
               check_field("pixel_pattern", 16'(rsp_tdata[40:33]),
                           16'(want.pixel_pattern));
               check_field("frame_done", 16'(rsp_tlast), 16'(want.frame_done));
               check_field("tdata pad", 16'(rsp_tdata[47:41]), 16'd0);
            end
         end
         if (cycle_count % 128 == 0) rx_style = $urandom_range(0, 3);
         if (long_hold_left != 0) begin
            rsp_tready <= 1'b0;
         end else begin
            case (rx_style)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= ($urandom_range(0, 3) != 0);
               2: rsp_tready <= (cycle_count % 5 != 0);
               default: rsp_tready <= ($urandom_range(0, 9) < 3);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin : stimulus
      int k, n, w, h, mode, stimulus_count;
      cfg.layout_mode = mvpf_pkg::RESET_LAYOUT_MODE;
      cfg.display_base = mvpf_pkg::RESET_DISPLAY_BASE;
      cfg.font_base = mvpf_pkg::RESET_FONT_BASE;
      cfg.bytes_wide = mvpf_pkg::RESET_BYTES_WIDE;
      cfg.lines_high = mvpf_pkg::RESET_LINES_HIGH;
      walk = '0;
      stimulus_count = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // idle transfer, then a start and a code under the reset registers
      queue_item(1'b0, 8'hFF);
      queue_item(1'b1, 8'h00);
      queue_item(1'b0, 8'h41);
      drain();

      // text frame with wrapping display and font addresses, then a restart
      write_reg(mvpf_pkg::REG_DISPLAY_BASE, 16'hFFFF);
      write_reg(mvpf_pkg::REG_FONT_BASE, 16'hFFF9);
      csr_valid <= 1'b0;
      queue_item(1'b1, 8'h5A);
      queue_item(1'b0, 8'hFF);
      queue_item(1'b0, 8'h00);
      queue_item(1'b0, 8'hFF);
      queue_item(1'b0, 8'h80);
      queue_item(1'b0, 8'h01);
      repeat (4) queue_item(1'b0, 8'($urandom));
      queue_item(1'b0, 8'h00);
      queue_item(1'b1, 8'hA5);
      drain();

      // empty frames: undefined layouts and sizes too small for the layout
      for (k = 0; k < 6; k++) begin
         case (k)
            0: write_reg(mvpf_pkg::REG_LAYOUT_MODE, {13'd0, MODE_UNDEF_LOW});
            1: write_reg(mvpf_pkg::REG_LAYOUT_MODE, {13'd0, MODE_UNDEF_HIGH});
            2: begin
               write_reg(mvpf_pkg::REG_LAYOUT_MODE, {13'd0, mvpf_pkg::MODE_TILES});
               write_reg(mvpf_pkg::REG_LINES_HIGH, 16'd7);
            end
            3: begin
               write_reg(mvpf_pkg::REG_LAYOUT_MODE, {13'd0, mvpf_pkg::MODE_SPRITES});
               write_reg(mvpf_pkg::REG_LINES_HIGH, 16'd21);
               write_reg(mvpf_pkg::REG_BYTES_WIDE, 16'd2);
            end
            4: begin
               write_reg(mvpf_pkg::REG_LAYOUT_MODE, {13'd0, mvpf_pkg::MODE_LINES});
               write_reg(mvpf_pkg::REG_BYTES_WIDE, 16'd0);
            end
            default: begin
               write_reg(mvpf_pkg::REG_BYTES_WIDE, 16'd1);
               write_reg(mvpf_pkg::REG_LINES_HIGH, 16'd0);
            end
         endcase
         csr_valid <= 1'b0;
         queue_item(1'b1, 8'($urandom));
         drain();
      end

      while (stimulus_count < 1300) begin
         mode = $urandom_range(0, 11);
         mode = (mode < 10) ? mode % 5 : $urandom_range(MODE_UNDEF_LOW, MODE_UNDEF_HIGH);
         write_reg(mvpf_pkg::REG_LAYOUT_MODE, 16'(mode));
         if ($urandom_range(0, 2) != 0)
            write_reg(mvpf_pkg::REG_DISPLAY_BASE, 16'(($urandom_range(0, 3) == 0) ?
                      16'hFFFF - $urandom_range(0, 20) : $urandom));
         if ($urandom_range(0, 2) != 0)
            write_reg(mvpf_pkg::REG_FONT_BASE, 16'(($urandom_range(0, 3) == 0) ?
                      16'hFFFF - $urandom_range(0, 20) : $urandom));
         if ($urandom_range(0, 9) == 0) begin
            // extremes, frames cut short
            k = $urandom_range(0, 2);
            write_reg(mvpf_pkg::REG_BYTES_WIDE,
                      16'((k == 0) ? 0 : (k == 1) ? 255 : $urandom_range(1, 255)));
            k = $urandom_range(0, 2);
            write_reg(mvpf_pkg::REG_LINES_HIGH,
                      16'((k == 0) ? 0 : (k == 1) ? 511 : $urandom_range(1, 511)));
         end else if ($urandom_range(0, 4) != 0) begin
            case (mode)
               mvpf_pkg::MODE_LINES, mvpf_pkg::MODE_COLUMNS: begin
                  w = $urandom_range(1, 8);
                  h = $urandom_range(1, 12);
               end
               mvpf_pkg::MODE_TILES: begin
                  w = $urandom_range(1, 5);
                  h = $urandom_range(8, 27);
               end
               mvpf_pkg::MODE_SPRITES: begin
                  w = $urandom_range(3, 7);
                  h = $urandom_range(21, 47);
               end
               mvpf_pkg::MODE_TEXT: begin
                  w = $urandom_range(1, 4);
                  h = $urandom_range(8, 19);
               end
               default: begin
                  w = $urandom_range(0, 9);
                  h = $urandom_range(0, 30);
               end
            endcase
            write_reg(mvpf_pkg::REG_BYTES_WIDE, 16'(w));
            write_reg(mvpf_pkg::REG_LINES_HIGH, 16'(h));
         end
         csr_valid <= 1'b0;

         // data without a start: an open frame runs on under new registers, or idle noise
         if ($urandom_range(0, 4) == 0) begin
            n = $urandom_range(1, 8);
            repeat (n) queue_item(1'b0, 8'($urandom));
            stimulus_count += n;
         end

         w = int'(cfg.bytes_wide);
         h = int'(cfg.lines_high);
         case (cfg.layout_mode)
            mvpf_pkg::MODE_LINES, mvpf_pkg::MODE_COLUMNS: n = w * h;
            mvpf_pkg::MODE_TILES: n = w * (h / 8) * 8;
            mvpf_pkg::MODE_SPRITES:
               n = (w / mvpf_pkg::SPR_BYTES) * (h / mvpf_pkg::SPR_LINES) *
                   mvpf_pkg::SPR_BYTES * mvpf_pkg::SPR_LINES;
            mvpf_pkg::MODE_TEXT: n = w * (h / 8) * 9;
            default: n = 0;
         endcase
         repeat ($urandom_range(1, 3)) begin
            k = n;
            if (k > FRAME_ITEMS_CAP || $urandom_range(0, 4) == 0)
               k = $urandom_range(0, (k > 120) ? 120 : k);
            queue_item(1'b1, 8'($urandom));
            repeat (k) queue_item(1'b0, 8'($urandom));
            stimulus_count += k + 1;
            if ($urandom_range(0, 3) == 0) queue_item(1'b0, 8'($urandom));
         end
         drain();
      end

      // receiver holds off while a full frame is offered
      write_reg(mvpf_pkg::REG_LAYOUT_MODE, {13'd0, mvpf_pkg::MODE_LINES});
      write_reg(mvpf_pkg::REG_BYTES_WIDE, 16'd16);
      write_reg(mvpf_pkg::REG_LINES_HIGH, 16'd8);
      csr_valid <= 1'b0;
      long_hold_req = 1'b1;
      queue_item(1'b1, 8'($urandom));
      repeat (128) queue_item(1'b0, 8'($urandom));
      drain();

      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
